/* rtl/gamepad_axis_conditioner_defines.svh */
// assertion macros shared by the gamepad axis conditioner rtl
`ifndef GAMEPAD_AXIS_CONDITIONER_DEFINES_SVH
`define GAMEPAD_AXIS_CONDITIONER_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define GAC_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gac assertion failed");

// consequent must hold in the same cycle as the antecedent
`define GAC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gac assertion failed");

`endif

/* rtl/gac_pkg.sv */
// types, widths and constants shared by the gamepad axis conditioner
`timescale 1ns / 1ps

package gac_pkg;

    // field widths
    localparam int BTN_W  = 12;
    localparam int ADC_W  = 10;
    localparam int CAL_W  = 10;
    localparam int CNT_W  = 2;
    localparam int RNG_W  = 11;
    localparam int P_W    = 12;
    localparam int S_W    = 11;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 11;

    // divider datapath widths
    localparam int NUM_W = 22;
    localparam int DEN_W = 10;
    localparam int V_W   = 24;

    // lane stages: difference, product, one per quotient bit, signed result
    localparam int LANE_DEPTH = NUM_W + 3;

    localparam logic [RNG_W-1:0] RANGE_CAP = 11'd1024;

    // stick count codes
    localparam logic [CNT_W-1:0] STICKS_PRIMARY = 2'd1;
    localparam logic [CNT_W-1:0] STICKS_BOTH    = 2'd2;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_X_LOW,
        REG_X_HIGH,
        REG_Y_LOW,
        REG_Y_HIGH,
        REG_X2_CTR,
        REG_Y2_CTR,
        REG_STICKS,
        REG_RANGE
    } gac_reg_t;

    typedef struct packed {
        logic [CAL_W-1:0] x_lo;
        logic [CAL_W-1:0] x_hi;
        logic [CAL_W-1:0] y_lo;
        logic [CAL_W-1:0] y_hi;
        logic [CAL_W-1:0] x2_ctr;
        logic [CAL_W-1:0] y2_ctr;
        logic [CNT_W-1:0] sticks;
        logic [RNG_W-1:0] range;
    } gac_cfg_t;

    localparam gac_cfg_t CFG_RESET = '{
        x_lo:   10'd150,
        x_hi:   10'd874,
        y_lo:   10'd110,
        y_hi:   10'd914,
        x2_ctr: 10'd512,
        y2_ctr: 10'd512,
        sticks: 2'd2,
        range:  11'd256
    };

    // per-stage load strobes for the lanes plus the output register
    typedef struct packed {
        logic [LANE_DEPTH-1:0] load;
        logic                  out_load;
    } gac_ctl_t;

    // full scale limited to the largest supported range
    function automatic logic [RNG_W-1:0] range_cap(input logic [RNG_W-1:0] r);
        return (r > RANGE_CAP) ? RANGE_CAP : r;
    endfunction

endpackage

/* rtl/gamepad_axis_conditioner.sv */
// top level of the gamepad axis conditioner: config, pipeline control, lanes
//
//  channel   direction  handshake            contents
//  in        receive    in_valid / in_stall   button levels, four adc readings
//  out       send       out_valid / out_stall pressed mask, four axes, cal flag
//  cfg       receive    cfg_valid / cfg_ready register index, write data
//
//  one sample set per cycle while out_stall holds no waiting result;
//  primary lanes: difference, product, 22 single-bit restoring divider
//  stages, signed result; reset loads the default calibration and empties
//  the pipeline; out_stall with a result waiting freezes the pipeline; an
//  empty first stage still takes one more request; cfg_ready is always high
`timescale 1ns / 1ps
`include "gamepad_axis_conditioner_defines.svh"

module gamepad_axis_conditioner #(
    parameter int DEADZONE = 16,
    parameter int ADC_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gac_pkg::BTN_W-1:0]         button_levels,
    input  logic [gac_pkg::ADC_W-1:0]         raw_x1,
    input  logic [gac_pkg::ADC_W-1:0]         raw_y1,
    input  logic [gac_pkg::ADC_W-1:0]         raw_x2,
    input  logic [gac_pkg::ADC_W-1:0]         raw_y2,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gac_pkg::BTN_W-1:0]         pressed_mask,
    output logic signed [gac_pkg::P_W-1:0]    axis_x1,
    output logic signed [gac_pkg::P_W-1:0]    axis_y1,
    output logic signed [gac_pkg::S_W-1:0]    axis_x2,
    output logic signed [gac_pkg::S_W-1:0]    axis_y2,
    output logic                              cal_invalid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gac_pkg::IDX_W-1:0]         cfg_index,
    input  logic [gac_pkg::DATA_W-1:0]        cfg_data
);

    localparam int AW        = gac_pkg::ADC_W;
    localparam int BW        = gac_pkg::BTN_W;
    localparam int RW        = gac_pkg::RNG_W;
    localparam int PW        = gac_pkg::P_W;
    localparam int DEPTH     = gac_pkg::LANE_DEPTH;
    localparam int MASK_BITS = (ADC_BITS < AW) ? ADC_BITS : AW;
    localparam logic [AW-1:0] ADC_MASK = AW'((64'd1 << MASK_BITS) - 64'd1);

    // configuration registers
    gac_pkg::gac_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= gac_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gac_pkg::gac_reg_t'(cfg_index))
                gac_pkg::REG_X_LOW:  cfg_reg.x_lo   <= cfg_data[9:0];
                gac_pkg::REG_X_HIGH: cfg_reg.x_hi   <= cfg_data[9:0];
                gac_pkg::REG_Y_LOW:  cfg_reg.y_lo   <= cfg_data[9:0];
                gac_pkg::REG_Y_HIGH: cfg_reg.y_hi   <= cfg_data[9:0];
                gac_pkg::REG_X2_CTR: cfg_reg.x2_ctr <= cfg_data[9:0];
                gac_pkg::REG_Y2_CTR: cfg_reg.y2_ctr <= cfg_data[9:0];
                gac_pkg::REG_STICKS: cfg_reg.sticks <= cfg_data[1:0];
                gac_pkg::REG_RANGE:  cfg_reg.range  <= cfg_data;
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    logic [RW-1:0] range_eff;

    assign range_eff = gac_pkg::range_cap(cfg_reg.range);

    // pipeline control: global advance, first stage also fills when empty
    logic [DEPTH-1:0]  vld_reg;
    logic              out_valid_reg;
    logic              adv;
    gac_pkg::gac_ctl_t ctl;

    assign adv          = !out_valid_reg || !out_stall;
    assign ctl.load     = {{(DEPTH-1){adv}}, adv || !vld_reg[0]};
    assign ctl.out_load = adv;
    assign in_stall     = !ctl.load[0];
    assign out_valid    = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv)
            begin
                vld_reg[DEPTH-1:1] <= vld_reg[DEPTH-2:0];
                out_valid_reg      <= vld_reg[DEPTH-1];
            end
        end
    end

    // button levels ride alongside the lanes
    logic [BW-1:0] btn_reg [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_btn
            if (i == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (ctl.load[0])
                    begin
                        btn_reg[0] <= button_levels;
                    end
                end
            end
            else
            begin : g_next
                always_ff @(posedge clk)
                begin
                    if (ctl.load[i])
                    begin
                        btn_reg[i] <= btn_reg[i-1];
                    end
                end
            end
        end
    endgenerate

    // axis lanes
    logic signed [gac_pkg::V_W-1:0] val_x1;
    logic signed [gac_pkg::V_W-1:0] val_y1;
    logic signed [gac_pkg::S_W-1:0] val_x2;
    logic signed [gac_pkg::S_W-1:0] val_y2;

    gac_primary_lane u_lane_x1 (
        .clk       (clk),
        .ctl       (ctl),
        .cal_lo    (cfg_reg.x_lo),
        .cal_hi    (cfg_reg.x_hi),
        .range_eff (range_eff),
        .raw       (raw_x1 & ADC_MASK),
        .value     (val_x1)
    );

    gac_primary_lane u_lane_y1 (
        .clk       (clk),
        .ctl       (ctl),
        .cal_lo    (cfg_reg.y_lo),
        .cal_hi    (cfg_reg.y_hi),
        .range_eff (range_eff),
        .raw       (raw_y1 & ADC_MASK),
        .value     (val_y1)
    );

    gac_offset_lane #(
        .DEADZONE (DEADZONE)
    ) u_lane_x2 (
        .clk    (clk),
        .ctl    (ctl),
        .centre (cfg_reg.x2_ctr),
        .raw    (raw_x2 & ADC_MASK),
        .value  (val_x2)
    );

    gac_offset_lane #(
        .DEADZONE (DEADZONE)
    ) u_lane_y2 (
        .clk    (clk),
        .ctl    (ctl),
        .centre (cfg_reg.y2_ctr),
        .raw    (raw_y2 & ADC_MASK),
        .value  (val_y2)
    );

    // merge and output register
    gac_merge #(
        .DEADZONE (DEADZONE)
    ) u_merge (
        .clk          (clk),
        .ctl          (ctl),
        .cfg          (cfg_reg),
        .range_eff    (range_eff),
        .levels       (btn_reg[DEPTH-1]),
        .val_x1       (val_x1),
        .val_y1       (val_y1),
        .val_x2       (val_x2),
        .val_y2       (val_y2),
        .pressed_mask (pressed_mask),
        .axis_x1      (axis_x1),
        .axis_y1      (axis_y1),
        .axis_x2      (axis_x2),
        .axis_y2      (axis_y2),
        .cal_invalid  (cal_invalid)
    );

    // checks
    logic signed [PW-1:0] range_s;

    assign range_s = signed'({{(PW-RW){1'b0}}, range_eff});

    `GAC_ASSERT_IMPLIES(a_stall_only_when_full, in_stall,
        vld_reg[0] && out_valid_reg && out_stall)
    `GAC_ASSERT_IMPLIES(a_flag_tracks_cal, out_valid,
        cal_invalid == ((cfg_reg.x_lo == cfg_reg.x_hi) || (cfg_reg.y_lo == cfg_reg.y_hi)))
    `GAC_ASSERT_IMPLIES(a_secondary_gated, out_valid && (cfg_reg.sticks != gac_pkg::STICKS_BOTH),
        (axis_x2 == '0) && (axis_y2 == '0))
    `GAC_ASSERT_HOLDS(a_primary_bounded, !out_valid ||
        ((axis_x1 <= range_s) && (axis_x1 >= -range_s) &&
         (axis_y1 <= range_s) && (axis_y1 >= -range_s)))

endmodule

/* rtl/gac_primary_lane.sv */
// primary stick lane: calibrated linear map through a pipelined divider
`timescale 1ns / 1ps

module gac_primary_lane (
    input  logic                                  clk,
    input  gac_pkg::gac_ctl_t                     ctl,
    input  logic [gac_pkg::CAL_W-1:0]             cal_lo,
    input  logic [gac_pkg::CAL_W-1:0]             cal_hi,
    input  logic [gac_pkg::RNG_W-1:0]             range_eff,
    input  logic [gac_pkg::ADC_W-1:0]             raw,
    output logic signed [gac_pkg::V_W-1:0]        value
);

    localparam int CW = gac_pkg::CAL_W;
    localparam int RW = gac_pkg::RNG_W;
    localparam int NW = gac_pkg::NUM_W;
    localparam int DW = gac_pkg::DEN_W;
    localparam int VW = gac_pkg::V_W;

    // divisor magnitude and sign, static between config writes
    logic [DW-1:0] dmag;
    logic          dneg;

    assign dneg = cal_lo > cal_hi;
    assign dmag = dneg ? DW'(cal_lo - cal_hi) : DW'(cal_hi - cal_lo);

    // offset from calibrated minimum, as magnitude and sign
    logic [CW-1:0] dif_reg;
    logic          dif_neg_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            dif_neg_reg <= raw < cal_lo;
            dif_reg     <= (raw < cal_lo) ? CW'(cal_lo - raw) : CW'(raw - cal_lo);
        end
    end

    // numerator magnitude times twice the range
    logic [NW-1:0] prod;
    logic [NW-1:0] num_reg;
    logic          neg1_reg;

    assign prod = {{(NW-CW){1'b0}}, dif_reg} * {{(NW-RW-1){1'b0}}, range_eff, 1'b0};

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            num_reg  <= prod;
            neg1_reg <= dif_neg_reg ^ dneg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] work_reg [NW];
    logic          neg_reg  [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_div
            logic [DW-1:0] rem_in;
            logic [NW-1:0] work_in;
            logic          neg_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign work_in = num_reg;
                assign neg_in  = neg1_reg;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign work_in = work_reg[k-1];
                assign neg_in  = neg_reg[k-1];
            end

            assign trial = {rem_in, work_in[NW-1]};
            assign ge    = trial >= {1'b0, dmag};
            assign diff  = trial - {1'b0, dmag};

            always_ff @(posedge clk)
            begin
                if (ctl.load[k+2])
                begin
                    rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    work_reg[k] <= {work_in[NW-2:0], ge};
                    neg_reg[k]  <= neg_in;
                end
            end
        end
    endgenerate

    // apply sign to the truncated quotient and remove the range offset
    logic signed [VW-1:0] q_ext;
    logic signed [VW-1:0] r_ext;
    logic signed [VW-1:0] value_reg;

    assign q_ext = signed'({{(VW-NW){1'b0}}, work_reg[NW-1]});
    assign r_ext = signed'({{(VW-RW){1'b0}}, range_eff});

    always_ff @(posedge clk)
    begin
        if (ctl.load[NW+2])
        begin
            value_reg <= neg_reg[NW-1] ? (-q_ext - r_ext) : (q_ext - r_ext);
        end
    end

    assign value = value_reg;

endmodule

/* rtl/gac_offset_lane.sv */
// secondary stick lane: centre offset and deadzone, delayed to lane depth
`timescale 1ns / 1ps

module gac_offset_lane #(
    parameter int DEADZONE = 16
) (
    input  logic                              clk,
    input  gac_pkg::gac_ctl_t                 ctl,
    input  logic [gac_pkg::CAL_W-1:0]         centre,
    input  logic [gac_pkg::ADC_W-1:0]         raw,
    output logic signed [gac_pkg::S_W-1:0]    value
);

    localparam int SW    = gac_pkg::S_W;
    localparam int DEPTH = gac_pkg::LANE_DEPTH;
    localparam logic signed [SW-1:0] DZ = SW'(DEADZONE);

    logic signed [SW-1:0] pipe_reg [DEPTH];
    logic signed [SW-1:0] diff;
    logic                 in_dead;

    // reading minus rest position
    assign diff    = signed'({1'b0, raw}) - signed'({1'b0, centre});
    assign in_dead = (pipe_reg[0] > -DZ) && (pipe_reg[0] < DZ);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            pipe_reg[0] <= diff;
        end
    end

    // deadzone
    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            pipe_reg[1] <= in_dead ? '0 : pipe_reg[0];
        end
    end

    // delay to match the primary lanes
    genvar i;
    generate
        for (i = 2; i < DEPTH; i++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (ctl.load[i])
                begin
                    pipe_reg[i] <= pipe_reg[i-1];
                end
            end
        end
    endgenerate

    assign value = pipe_reg[DEPTH-1];

endmodule

/* rtl/gac_merge.sv */
// merge stage: primary deadzone and saturation, stick gating and output register
`timescale 1ns / 1ps

module gac_merge #(
    parameter int DEADZONE = 16
) (
    input  logic                              clk,
    input  gac_pkg::gac_ctl_t                 ctl,
    input  gac_pkg::gac_cfg_t                 cfg,
    input  logic [gac_pkg::RNG_W-1:0]         range_eff,
    input  logic [gac_pkg::BTN_W-1:0]         levels,
    input  logic signed [gac_pkg::V_W-1:0]    val_x1,
    input  logic signed [gac_pkg::V_W-1:0]    val_y1,
    input  logic signed [gac_pkg::S_W-1:0]    val_x2,
    input  logic signed [gac_pkg::S_W-1:0]    val_y2,
    output logic [gac_pkg::BTN_W-1:0]         pressed_mask,
    output logic signed [gac_pkg::P_W-1:0]    axis_x1,
    output logic signed [gac_pkg::P_W-1:0]    axis_y1,
    output logic signed [gac_pkg::S_W-1:0]    axis_x2,
    output logic signed [gac_pkg::S_W-1:0]    axis_y2,
    output logic                              cal_invalid
);

    localparam int VW = gac_pkg::V_W;
    localparam int PW = gac_pkg::P_W;
    localparam int RW = gac_pkg::RNG_W;
    localparam int BW = gac_pkg::BTN_W;
    localparam int SW = gac_pkg::S_W;
    localparam logic signed [VW-1:0] DZ = VW'(DEADZONE);

    // deadzone then clamp to plus or minus the range
    function automatic logic signed [PW-1:0] finish(
        input logic signed [VW-1:0] v,
        input logic [RW-1:0]        r
    );
        logic signed [VW-1:0] rs;
        logic signed [VW-1:0] t;
        rs = signed'({{(VW-RW){1'b0}}, r});
        t  = ((v > -DZ) && (v < DZ)) ? '0 : v;
        priority if (t > rs)
            t = rs;
        else if (t < -rs)
            t = -rs;
        return PW'(t);
    endfunction

    logic x_bad;
    logic y_bad;
    logic prim_on;
    logic sec_on;

    assign x_bad   = cfg.x_lo == cfg.x_hi;
    assign y_bad   = cfg.y_lo == cfg.y_hi;
    assign prim_on = (cfg.sticks == gac_pkg::STICKS_PRIMARY) ||
                     (cfg.sticks == gac_pkg::STICKS_BOTH);
    assign sec_on  = cfg.sticks == gac_pkg::STICKS_BOTH;

    logic [BW-1:0]        mask_reg;
    logic signed [PW-1:0] x1_reg;
    logic signed [PW-1:0] y1_reg;
    logic signed [SW-1:0] x2_reg;
    logic signed [SW-1:0] y2_reg;
    logic                 bad_reg;

    // output register
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            mask_reg <= ~levels;
            x1_reg   <= (prim_on && !x_bad) ? finish(val_x1, range_eff) : '0;
            y1_reg   <= (prim_on && !y_bad) ? finish(val_y1, range_eff) : '0;
            x2_reg   <= sec_on ? val_x2 : '0;
            y2_reg   <= sec_on ? val_y2 : '0;
            bad_reg  <= x_bad || y_bad;
        end
    end

    assign pressed_mask = mask_reg;
    assign axis_x1      = x1_reg;
    assign axis_y1      = y1_reg;
    assign axis_x2      = x2_reg;
    assign axis_y2      = y2_reg;
    assign cal_invalid  = bad_reg;

endmodule

/* dv/gamepad_axis_conditioner_tb.sv */
// self-checking testbench for the gamepad axis conditioner
`timescale 1ns / 1ps

module gamepad_axis_conditioner_tb;

    import gac_pkg::*;

    localparam int DEAD_BAND = 16;
    localparam int FLUSH_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 190;

    // one sample set as presented to the block
    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [ADC_W-1:0] x1;
        logic [ADC_W-1:0] y1;
        logic [ADC_W-1:0] x2;
        logic [ADC_W-1:0] y2;
    } sample_t;

    // one conditioned result
    typedef struct packed {
        logic [BTN_W-1:0]      mask;
        logic signed [P_W-1:0] x1;
        logic signed [P_W-1:0] y1;
        logic signed [S_W-1:0] x2;
        logic signed [S_W-1:0] y2;
        logic                  bad;
    } axes_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    // directed row: a register write or a sample, optionally with its result typed in
    typedef struct packed {
        row_kind_t         kind;
        gac_reg_t          target;
        logic [DATA_W-1:0] wdata;
        sample_t           smp;
        logic              typed;
        axes_t             want;
    } row_t;

    localparam int N_DIR = 35;
    localparam row_t DIR_ROWS [N_DIR] = '{
        // reset calibration: rest, full low, full high, beyond bounds, deadzone edges
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hFFF, 10'd512, 10'd512, 10'd512, 10'd512},
          1'b1, '{12'h000, 12'sd0, 12'sd0, 11'sd0, 11'sd0, 1'b0}},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h000, 10'd150, 10'd110, 10'd0, 10'd0},
          1'b1, '{12'hFFF, -12'sd256, -12'sd256, -11'sd512, -11'sd512, 1'b0}},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hA5A, 10'd874, 10'd914, 10'd1023, 10'd1023},
          1'b1, '{12'h5A5, 12'sd256, 12'sd256, 11'sd511, 11'sd511, 1'b0}},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h5A5, 10'd0, 10'd0, 10'd527, 10'd497},
          1'b1, '{12'hA5A, -12'sd256, -12'sd256, 11'sd0, 11'sd0, 1'b0}},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h123, 10'd1023, 10'd1023, 10'd528, 10'd496},
          1'b1, '{12'hEDC, 12'sd256, 12'sd256, 11'sd16, -11'sd16, 1'b0}},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h800, 10'd534, 10'd520, 10'd600, 10'd400},
          1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h001, 10'd300, 10'd700, 10'd100, 10'd900},
          1'b0, '0},
        // primary stick only
        '{ROW_WRITE, REG_STICKS, 11'd1, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hFFE, 10'd1023, 10'd0, 10'd0, 10'd1023},
          1'b0, '0},
        // no sticks, both codes
        '{ROW_WRITE, REG_STICKS, 11'd0, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hF0F, 10'd1023, 10'd1023, 10'd1023, 10'd1023},
          1'b1, '{12'h0F0, 12'sd0, 12'sd0, 11'sd0, 11'sd0, 1'b0}},
        '{ROW_WRITE, REG_STICKS, 11'd3, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h0F0, 10'd0, 10'd0, 10'd0, 10'd0},
          1'b1, '{12'hF0F, 12'sd0, 12'sd0, 11'sd0, 11'sd0, 1'b0}},
        '{ROW_WRITE, REG_STICKS, 11'd2, '0, 1'b0, '0},
        // zero range, range above the cap, range at the cap
        '{ROW_WRITE, REG_RANGE, 11'd0, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hF00, 10'd0, 10'd1023, 10'd700, 10'd300},
          1'b0, '0},
        '{ROW_WRITE, REG_RANGE, 11'd2047, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h00F, 10'd1023, 10'd0, 10'd512, 10'd512},
          1'b0, '0},
        '{ROW_WRITE, REG_RANGE, 11'd1024, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h3C3, 10'd900, 10'd50, 10'd512, 10'd512},
          1'b0, '0},
        // equal x bounds
        '{ROW_WRITE, REG_X_LOW, 11'd874, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hC3C, 10'd600, 10'd600, 10'd300, 10'd700},
          1'b0, '0},
        // inverted x calibration mirrors the axis
        '{ROW_WRITE, REG_X_LOW, 11'd900, '0, 1'b0, '0},
        '{ROW_WRITE, REG_X_HIGH, 11'd100, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h555, 10'd100, 10'd512, 10'd512, 10'd512},
          1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'hAAA, 10'd900, 10'd512, 10'd512, 10'd512},
          1'b0, '0},
        // equal y bounds flag the result even with no sticks
        '{ROW_WRITE, REG_Y_LOW, 11'd1023, '0, 1'b0, '0},
        '{ROW_WRITE, REG_Y_HIGH, 11'd1023, '0, 1'b0, '0},
        '{ROW_WRITE, REG_STICKS, 11'd0, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h777, 10'd512, 10'd512, 10'd512, 10'd512},
          1'b1, '{12'h888, 12'sd0, 12'sd0, 11'sd0, 11'sd0, 1'b1}},
        // extreme centres, unused upper data bits set
        '{ROW_WRITE, REG_X2_CTR, 11'h400, '0, 1'b0, '0},
        '{ROW_WRITE, REG_Y2_CTR, 11'd1023, '0, 1'b0, '0},
        '{ROW_WRITE, REG_STICKS, 11'h402, '0, 1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h999, 10'd512, 10'd512, 10'd1023, 10'd0},
          1'b0, '0},
        '{ROW_SAMPLE, REG_X_LOW, 11'd0, '{12'h666, 10'd512, 10'd512, 10'd0, 10'd1023},
          1'b0, '0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [BTN_W-1:0]         button_levels = '0;
    logic [ADC_W-1:0]         raw_x1 = '0;
    logic [ADC_W-1:0]         raw_y1 = '0;
    logic [ADC_W-1:0]         raw_x2 = '0;
    logic [ADC_W-1:0]         raw_y2 = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [BTN_W-1:0]         pressed_mask;
    logic signed [P_W-1:0]    axis_x1;
    logic signed [P_W-1:0]    axis_y1;
    logic signed [S_W-1:0]    axis_x2;
    logic signed [S_W-1:0]    axis_y2;
    logic                     cal_invalid;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;

    gac_cfg_t cal_regs = CFG_RESET;
    axes_t    pending_axes [$];
    int       mismatches = 0;
    int       sender_gap_pct = 0;
    int       sink_stall_pct = 0;

    gamepad_axis_conditioner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_levels (button_levels),
        .raw_x1        (raw_x1),
        .raw_y1        (raw_y1),
        .raw_x2        (raw_x2),
        .raw_y2        (raw_y2),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pressed_mask  (pressed_mask),
        .axis_x1       (axis_x1),
        .axis_y1       (axis_y1),
        .axis_x2       (axis_x2),
        .axis_y2       (axis_y2),
        .cal_invalid   (cal_invalid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // values inside the deadzone collapse to zero
    function automatic int deadzone(input int v);
        return (v < DEAD_BAND && v > -DEAD_BAND) ? 0 : v;
    endfunction

    // linear map of a primary reading onto -rng..+rng, truncating division
    function automatic int map_primary(input logic [ADC_W-1:0] raw,
                                       input logic [CAL_W-1:0] lo,
                                       input logic [CAL_W-1:0] hi,
                                       input int rng, inout logic bad);
        longint a;
        longint l;
        longint h;
        longint v;
        a = raw;
        l = lo;
        h = hi;
        if (lo == hi)
        begin
            bad = 1'b1;
            return 0;
        end
        v = ((a - l) * (2 * rng)) / (h - l) - rng;
        v = deadzone(int'(v));
        if (v > rng)
            v = rng;
        if (v < -rng)
            v = -rng;
        return int'(v);
    endfunction

    // expected conditioned result of one sample set under the given calibration
    function automatic axes_t condition_sample(input gac_cfg_t c, input sample_t s);
        axes_t r;
        int    rng;
        int    x1;
        int    y1;
        int    x2;
        int    y2;
        int    rx2;
        int    ry2;
        int    cx2;
        int    cy2;
        logic  bad;
        rng = (c.range > RANGE_CAP) ? int'(RANGE_CAP) : int'(c.range);
        bad = 1'b0;
        x1 = map_primary(s.x1, c.x_lo, c.x_hi, rng, bad);
        y1 = map_primary(s.y1, c.y_lo, c.y_hi, rng, bad);
        rx2 = s.x2;
        ry2 = s.y2;
        cx2 = c.x2_ctr;
        cy2 = c.y2_ctr;
        x2 = deadzone(rx2 - cx2);
        y2 = deadzone(ry2 - cy2);
        if (c.sticks != STICKS_PRIMARY && c.sticks != STICKS_BOTH)
        begin
            x1 = 0;
            y1 = 0;
        end
        if (c.sticks != STICKS_BOTH)
        begin
            x2 = 0;
            y2 = 0;
        end
        r.mask = ~s.buttons;
        r.x1 = x1[P_W-1:0];
        r.y1 = y1[P_W-1:0];
        r.x2 = x2[S_W-1:0];
        r.y2 = y2[S_W-1:0];
        r.bad = bad;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 200)
            $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        axes_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_axes.size() == 0)
                report_mismatch("unexpected result", int'(pressed_mask), 0);
            else
            begin
                want = pending_axes.pop_front();
                if (pressed_mask !== want.mask)
                    report_mismatch("pressed_mask", int'(pressed_mask), int'(want.mask));
                if (axis_x1 !== want.x1)
                    report_mismatch("axis_x1", int'(axis_x1), int'(want.x1));
                if (axis_y1 !== want.y1)
                    report_mismatch("axis_y1", int'(axis_y1), int'(want.y1));
                if (axis_x2 !== want.x2)
                    report_mismatch("axis_x2", int'(axis_x2), int'(want.x2));
                if (axis_y2 !== want.y2)
                    report_mismatch("axis_y2", int'(axis_y2), int'(want.y2));
                if (cal_invalid !== want.bad)
                    report_mismatch("cal_invalid", int'(cal_invalid), int'(want.bad));
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < sink_stall_pct);

    // all tasks below start and end just after a falling edge

    // hold off new requests until every expected result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_axes.size() != 0)
            @(negedge clk);
    endtask

    // register write, only with the pipeline empty
    task automatic write_reg(input gac_reg_t idx, input logic [DATA_W-1:0] d);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_LOW:  cal_regs.x_lo   = d[CAL_W-1:0];
            REG_X_HIGH: cal_regs.x_hi   = d[CAL_W-1:0];
            REG_Y_LOW:  cal_regs.y_lo   = d[CAL_W-1:0];
            REG_Y_HIGH: cal_regs.y_hi   = d[CAL_W-1:0];
            REG_X2_CTR: cal_regs.x2_ctr = d[CAL_W-1:0];
            REG_Y2_CTR: cal_regs.y2_ctr = d[CAL_W-1:0];
            REG_STICKS: cal_regs.sticks = d[CNT_W-1:0];
            REG_RANGE:  cal_regs.range  = d;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one sample request; the expectation is queued when the block takes it
    task automatic send_sample(input sample_t s, input logic typed, input axes_t want);
        logic took;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        button_levels <= s.buttons;
        raw_x1        <= s.x1;
        raw_y1        <= s.y1;
        raw_x2        <= s.x2;
        raw_y2        <= s.y2;
        do
        begin
            @(posedge clk);
            took = !in_stall;
            if (took)
                pending_axes.push_back(typed ? want : condition_sample(cal_regs, s));
            @(negedge clk);
        end
        while (!took);
    endtask

    // reading near a bound, near the middle, at an extreme or anywhere
    function automatic logic [ADC_W-1:0] pick_reading(input logic [CAL_W-1:0] lo,
                                                      input logic [CAL_W-1:0] hi);
        logic [CAL_W:0] mid;
        mid = ({1'b0, lo} + {1'b0, hi}) >> 1;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return lo + ADC_W'($urandom_range(24)) - ADC_W'(12);
            3: return hi + ADC_W'($urandom_range(24)) - ADC_W'(12);
            4: return mid[ADC_W-1:0] + ADC_W'($urandom_range(80)) - ADC_W'(40);
            default: return ADC_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [CAL_W-1:0] pick_bound(input logic upper);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return upper ? CAL_W'($urandom_range(1023, 560))
                                  : CAL_W'($urandom_range(460, 0));
        endcase
    endfunction

    // 10-bit register value with a random unused top bit
    function automatic logic [DATA_W-1:0] with_spare(input logic [CAL_W-1:0] v);
        return {1'($urandom_range(1)), v};
    endfunction

    // rewrite every register, fixed extremes or a random setting
    task automatic load_setting(input logic extremes);
        logic [CAL_W-1:0]  xl;
        logic [CAL_W-1:0]  xh;
        logic [CAL_W-1:0]  yl;
        logic [CAL_W-1:0]  yh;
        logic [CAL_W-1:0]  cx;
        logic [CAL_W-1:0]  cy;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] rng;
        if (extremes)
        begin
            xl = '0;
            xh = '1;
            yl = '1;
            yh = '0;
            cx = '0;
            cy = '1;
            cnt = STICKS_BOTH;
            rng = RANGE_CAP;
        end
        else
        begin
            xl = pick_bound(1'b0);
            xh = pick_bound(1'b1);
            if ($urandom_range(7) == 0)
                xh = xl;
            yl = pick_bound(1'b0);
            yh = pick_bound(1'b1);
            if ($urandom_range(7) == 0)
                yh = yl;
            cx = pick_bound(1'($urandom_range(1)));
            cy = pick_bound(1'($urandom_range(1)));
            case ($urandom_range(9))
                0: cnt = 2'd0;
                1: cnt = 2'd3;
                2, 3: cnt = STICKS_PRIMARY;
                default: cnt = STICKS_BOTH;
            endcase
            case ($urandom_range(7))
                0: rng = '0;
                1: rng = '1;
                2: rng = RANGE_CAP;
                3: rng = 11'd1;
                4: rng = 11'd256;
                5: rng = 11'd512;
                default: rng = DATA_W'($urandom_range(2047));
            endcase
        end
        write_reg(REG_X_LOW, with_spare(xl));
        write_reg(REG_X_HIGH, with_spare(xh));
        write_reg(REG_Y_LOW, with_spare(yl));
        write_reg(REG_Y_HIGH, with_spare(yh));
        write_reg(REG_X2_CTR, with_spare(cx));
        write_reg(REG_Y2_CTR, with_spare(cy));
        write_reg(REG_STICKS, {9'($urandom_range(511)), cnt});
        write_reg(REG_RANGE, rng);
    endtask

    // stimulus
    initial
    begin
        sample_t s;
        row_t    row;
        int      mode;
        sender_gap_pct = 29;
        sink_stall_pct = 46;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int k = 0; k < N_DIR; k++)
        begin
            row = DIR_ROWS[k];
            if (row.kind == ROW_WRITE)
                write_reg(row.target, row.wdata);
            else
                send_sample(row.smp, row.typed, row.want);
        end

        // random phases, each under its own calibration
        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = (ph * 3) / PHASES;
            sender_gap_pct = (mode == 0) ? 29 : (mode == 1) ? 46 : 0;
            sink_stall_pct = (mode == 0) ? 46 : (mode == 1) ? 29 : 0;
            load_setting(ph == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                s.buttons = BTN_W'($urandom_range(4095));
                s.x1 = pick_reading(cal_regs.x_lo, cal_regs.x_hi);
                s.y1 = pick_reading(cal_regs.y_lo, cal_regs.y_hi);
                s.x2 = pick_reading(cal_regs.x2_ctr, cal_regs.x2_ctr);
                s.y2 = pick_reading(cal_regs.y2_ctr, cal_regs.y2_ctr);
                send_sample(s, 1'b0, '0);
            end
        end

        drain_results();
        repeat (FLUSH_CYCLES)
            @(negedge clk);
        if (mismatches == 0 && pending_axes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* gamepad_axis_conditioner.f */
+incdir+rtl
rtl/gac_pkg.sv
rtl/gac_primary_lane.sv
rtl/gac_offset_lane.sv
rtl/gac_merge.sv
rtl/gamepad_axis_conditioner.sv
dv/gamepad_axis_conditioner_tb.sv
